// ----- hdl/tsam_pkg.sv -----
`default_nettype none
package tsam_pkg;

  // field widths
  localparam int RAW_W     = 16;
  localparam int RAW_SHIFT = 3;
  localparam int AVG_W     = RAW_W - RAW_SHIFT;   // scaled sample / average
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = AVG_W + GAIN_W;      // full product width
  localparam int FRAC_BITS = 13;                  // Q3.13 gain
  localparam int POS_W     = 16;
  localparam int DIM_W     = 12;
  localparam int ORI_W     = 3;
  localparam int EV_W      = 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd1;
  localparam logic [EV_W-1:0] EV_UP   = 2'd2;

  // orientation codes
  localparam logic [ORI_W-1:0] ORI_ROT_A = 3'd2;
  localparam logic [ORI_W-1:0] ORI_ROT_B = 3'd3;
  localparam logic [ORI_W-1:0] ORI_ROT_C = 3'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_X_GAIN   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_Y_GAIN   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_X_OFFSET = 3'd2;
  localparam logic [CFG_AW-1:0] REG_Y_OFFSET = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ORIENT   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_WIDTH    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_HEIGHT   = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd8192;
  localparam logic [ORI_W-1:0]  ORI_RST    = 3'd1;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 12'd240;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 12'd320;

endpackage
`default_nettype wire

// ----- hdl/tsam_hist.sv -----
`default_nettype none
// History line for one axis, newest in entry 0, with a serial summer
// that adds one filled entry per cycle.
module tsam_hist #(
  parameter int DEPTH = 4,
  parameter int CNT_W = 3,
  parameter int SUM_W = 15
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire logic signed [tsam_pkg::AVG_W-1:0] push_data,
  input  wire logic                              sum_start,
  input  wire logic [CNT_W-1:0]                  count,
  output logic                                   sum_done,
  output logic signed [SUM_W-1:0]                sum
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [tsam_pkg::AVG_W-1:0] hist_r [DEPTH];
  logic signed [SUM_W-1:0]           acc_r;
  logic [IDX_W-1:0]                  idx_r;
  logic                              busy_r;
  logic                              done_r;
  logic                              last;

  assign last     = (CNT_W'(idx_r) == (count - 1'b1));
  assign sum_done = done_r;
  assign sum      = acc_r;

  // shift line, no reset: only filled entries are summed
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= push_data;
    end
  end

  // control of the summer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (sum_start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one entry per cycle into the accumulator
  always_ff @(posedge clk) begin
    if (sum_start) begin
      acc_r <= '0;
      idx_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + SUM_W'(hist_r[idx_r]);
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tsam_div.sv -----
`default_nettype none
// Bit-serial restoring divider: signed sum over a small unsigned count,
// quotient truncated toward zero, one quotient bit per cycle.
module tsam_div #(
  parameter int SUM_W = 15,
  parameter int CNT_W = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [SUM_W-1:0]           dividend,
  input  wire logic [CNT_W-1:0]                  divisor,
  output logic                                   done,
  output logic signed [tsam_pkg::AVG_W-1:0]      quot
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic [SUM_W-1:0]  mag_r;     // dividend bits out, quotient bits in
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_sub;
  logic [SUM_W-1:0]  q_signed;

  assign rem_sh   = {rem_r, mag_r[SUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign rem_sub  = rem_sh - {1'b0, div_r};
  assign q_signed = neg_r ? (~mag_r + 1'b1) : mag_r;
  assign quot     = q_signed[tsam_pkg::AVG_W-1:0];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      neg_r  <= dividend[SUM_W-1];
      rem_r  <= '0;
      div_r  <= divisor;
      step_r <= STEP_W'(SUM_W - 1);
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      mag_r  <= {mag_r[SUM_W-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tsam_mul.sv -----
`default_nettype none
// Bit-serial signed multiplier: one multiplier bit per cycle, the sign
// bit weighted negative.
module tsam_mul (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [tsam_pkg::AVG_W-1:0]  mplier,
  input  wire logic signed [tsam_pkg::GAIN_W-1:0] mcand,
  output logic                                    done,
  output logic signed [tsam_pkg::PROD_W-1:0]      prod
);

  localparam int STEP_W = $clog2(tsam_pkg::AVG_W);

  logic signed [tsam_pkg::PROD_W-1:0] acc_r;
  logic signed [tsam_pkg::PROD_W-1:0] mcand_r;
  logic [tsam_pkg::AVG_W-1:0]         mplier_r;
  logic [STEP_W-1:0]                  step_r;
  logic                               busy_r;
  logic                               done_r;
  logic                               last;
  logic signed [tsam_pkg::PROD_W-1:0] part;

  assign last = (step_r == STEP_W'(tsam_pkg::AVG_W - 1));
  assign part = mplier_r[0] ? mcand_r : '0;
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift-and-add, subtract on the sign bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= tsam_pkg::PROD_W'(mcand);
      mplier_r <= mplier;
      step_r   <= '0;
    end else if (busy_r) begin
      acc_r    <= last ? (acc_r - part) : (acc_r + part);
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
      step_r   <= step_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/touch_sample_average_and_map.sv -----
// Pen-down item: taken, summed, divided, multiplied and mapped, then loaded into the output
// register; SUM_W = 13 + log2(AVERAGE_DEPTH). Serial summer one entry a cycle, then the
// bit-serial divider and the bit-serial multiplier. Pen-up item: goes straight to the output
// register. Both wait in S_OUT while the output register holds an untaken result.
// One item in flight; the output register holds a result while the next item is taken.
// Synchronous active-low reset: registers to defaults, fill count and touch flag cleared.
`default_nettype none
module touch_sample_average_and_map #(
  parameter int AVERAGE_DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input items
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [31:0]                  in_tdata,   // raw_x[15:0], raw_y[31:16]
  input  wire logic [0:0]                   in_tuser,   // pen_down[0]
  // result items
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [31:0]                       out_tdata,  // pos_x[15:0], pos_y[31:16]
  output logic [tsam_pkg::EV_W-1:0]         out_tuser,  // event_res[1:0]
  // register writes
  input  wire logic                         cfg_we,
  input  wire logic [tsam_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [tsam_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(AVERAGE_DEPTH + 1);
  localparam int SUM_W = tsam_pkg::AVG_W + $clog2(AVERAGE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUMGO = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // registers
  logic signed [tsam_pkg::GAIN_W-1:0] x_gain_r, y_gain_r;
  logic [tsam_pkg::POS_W-1:0]         x_off_r, y_off_r;
  logic [tsam_pkg::ORI_W-1:0]         orient_r;
  logic [tsam_pkg::DIM_W-1:0]         width_r, height_r;

  logic [2:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           fill_r;
  logic                       touch_r;
  logic [tsam_pkg::EV_W-1:0]  res_ev_r;
  logic [tsam_pkg::POS_W-1:0] res_x_r, res_y_r;
  logic                       out_valid_r;
  logic [31:0]                out_data_r;
  logic [tsam_pkg::EV_W-1:0]  out_user_r;

  logic                                accept;
  logic                                pen;
  logic signed [tsam_pkg::AVG_W-1:0]   scaled_x, scaled_y;
  logic                                sum_start, div_start, mul_start;
  logic                                hx_done, hy_done, dx_done, dy_done, mx_done, my_done;
  logic signed [SUM_W-1:0]             sum_x, sum_y;
  logic signed [tsam_pkg::AVG_W-1:0]   avg_x, avg_y;
  logic signed [tsam_pkg::PROD_W-1:0]  prod_x, prod_y;
  logic [tsam_pkg::POS_W-1:0]          map_x, map_y, wid16, hgt16, rot_x, rot_y;
  logic                                out_load;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign pen       = in_tuser[0];
  assign scaled_x  = in_tdata[15:tsam_pkg::RAW_SHIFT];
  assign scaled_y  = in_tdata[31:16+tsam_pkg::RAW_SHIFT];
  assign sum_start = (state_r == S_SUMGO);
  assign div_start = (state_r == S_SUM) && hx_done;
  assign mul_start = (state_r == S_DIV) && dx_done;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r <= tsam_pkg::GAIN_RST;
      y_gain_r <= tsam_pkg::GAIN_RST;
      x_off_r  <= '0;
      y_off_r  <= '0;
      orient_r <= tsam_pkg::ORI_RST;
      width_r  <= tsam_pkg::WIDTH_RST;
      height_r <= tsam_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tsam_pkg::REG_X_GAIN:   x_gain_r <= cfg_wdata;
        tsam_pkg::REG_Y_GAIN:   y_gain_r <= cfg_wdata;
        tsam_pkg::REG_X_OFFSET: x_off_r  <= cfg_wdata;
        tsam_pkg::REG_Y_OFFSET: y_off_r  <= cfg_wdata;
        tsam_pkg::REG_ORIENT:   orient_r <= cfg_wdata[tsam_pkg::ORI_W-1:0];
        tsam_pkg::REG_WIDTH:    width_r  <= cfg_wdata[tsam_pkg::DIM_W-1:0];
        tsam_pkg::REG_HEIGHT:   height_r <= cfg_wdata[tsam_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // per-axis units
  tsam_hist #(.DEPTH(AVERAGE_DEPTH), .CNT_W(CNT_W), .SUM_W(SUM_W)) u_hist_x (
    .clk, .rst_n, .push(accept && pen), .push_data(scaled_x),
    .sum_start, .count(fill_r), .sum_done(hx_done), .sum(sum_x)
  );
  tsam_hist #(.DEPTH(AVERAGE_DEPTH), .CNT_W(CNT_W), .SUM_W(SUM_W)) u_hist_y (
    .clk, .rst_n, .push(accept && pen), .push_data(scaled_y),
    .sum_start, .count(fill_r), .sum_done(hy_done), .sum(sum_y)
  );
  tsam_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
    .clk, .rst_n, .start(div_start), .dividend(sum_x), .divisor(fill_r),
    .done(dx_done), .quot(avg_x)
  );
  tsam_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
    .clk, .rst_n, .start(div_start), .dividend(sum_y), .divisor(fill_r),
    .done(dy_done), .quot(avg_y)
  );
  tsam_mul u_mul_x (
    .clk, .rst_n, .start(mul_start), .mplier(avg_x), .mcand(x_gain_r),
    .done(mx_done), .prod(prod_x)
  );
  tsam_mul u_mul_y (
    .clk, .rst_n, .start(mul_start), .mplier(avg_y), .mcand(y_gain_r),
    .done(my_done), .prod(prod_y)
  );

  // floor of product over 2^13, plus offset, rotate and clamp
  always_comb begin
    map_x = prod_x[tsam_pkg::PROD_W-1 -: tsam_pkg::POS_W] + x_off_r;
    map_y = prod_y[tsam_pkg::PROD_W-1 -: tsam_pkg::POS_W] + y_off_r;
    wid16 = tsam_pkg::POS_W'(width_r);
    hgt16 = tsam_pkg::POS_W'(height_r);
    case (orient_r)
      tsam_pkg::ORI_ROT_A: begin
        rot_x = map_y;
        rot_y = hgt16 - map_x;
      end
      tsam_pkg::ORI_ROT_B: begin
        rot_x = wid16 - map_x;
        rot_y = hgt16 - map_y;
      end
      tsam_pkg::ORI_ROT_C: begin
        rot_x = wid16 - map_y;
        rot_y = map_x;
      end
      default: begin
        rot_x = map_x;
        rot_y = map_y;
      end
    endcase
    if ((rot_x >= wid16) || (rot_y >= hgt16)) begin
      rot_x = wid16;
      rot_y = hgt16;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = pen ? S_SUMGO : S_OUT;
      S_SUMGO: state_nxt = S_SUM;
      S_SUM:   if (hx_done) state_nxt = S_DIV;
      S_DIV:   if (dx_done) state_nxt = S_MUL;
      S_MUL:   if (mx_done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      touch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        touch_r <= pen;
        if (!pen) begin
          fill_r <= '0;
        end else if (fill_r < CNT_W'(AVERAGE_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (accept && !pen) begin
      res_ev_r <= touch_r ? tsam_pkg::EV_UP : tsam_pkg::EV_NONE;
      res_x_r  <= '0;
      res_y_r  <= '0;
    end else if ((state_r == S_MUL) && mx_done) begin
      res_ev_r <= tsam_pkg::EV_DOWN;
      res_x_r  <= rot_x;
      res_y_r  <= rot_y;
    end
    if (out_load) begin
      out_data_r <= {res_y_r, res_x_r};
      out_user_r <= res_ev_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(AVERAGE_DEPTH))
    else $error("fill count above history depth");

  a_axes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (hx_done == hy_done) && (dx_done == dy_done) && (mx_done == my_done))
    else $error("x and y units out of step");

  a_pen_down_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pen |=> (state_r == S_SUMGO) && (fill_r != '0))
    else $error("pen-down item did not start averaging");

  a_pen_up_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !pen |=> (state_r == S_OUT) && (fill_r == '0) && !touch_r)
    else $error("pen-up item not handled");

endmodule
`default_nettype wire
